/* hdl/csoc_pkg.sv */
package csoc_pkg;

    localparam int MAX_SPANS  = 256;
    localparam int IDX_W      = $clog2(MAX_SPANS);
    localparam int CNT_W      = $clog2(MAX_SPANS + 1);
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_SIZE,
        ST_OUTSIDE,
        ST_HEADER,
        ST_NAMES,
        ST_OVERLAP,
        ST_FULL,
        ST_FAILED
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARCHIVE_LEN  = 8'd0,
        REG_HEADER_END   = 8'd1,
        REG_NAMES_START  = 8'd2,
        REG_NAMES_END    = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CHECK,
        FSM_SCAN,
        FSM_FINISH
    } fsm_t;

    // half-open span [start, stop)
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
    } span_t;

    // token and accumulated overlap flag moving along the cell row
    typedef struct packed {
        logic tok;
        logic hit;
    } probe_t;

endpackage

/* hdl/csoc_cell.sv */
module csoc_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             wr_en,
    input  csoc_pkg::span_t  query,
    input  csoc_pkg::probe_t probe_in,
    output csoc_pkg::probe_t probe_out
);
    import csoc_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    span_t  span_reg;
    probe_t probe_reg;
    probe_t probe_next;
    logic   dup;
    logic   overlap;

    always_comb
    begin
        dup     = (span_reg.start == query.start) && (span_reg.stop == query.stop);
        overlap = valid_reg && !dup
                  && (query.start < span_reg.stop) && (span_reg.start < query.stop);
        probe_next.tok = probe_in.tok;
        probe_next.hit = probe_in.hit | (probe_in.tok & overlap);
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            span_reg <= query;
        end
    end

    assign probe_out = probe_reg;

endmodule

/* hdl/csoc_chain.sv */
module csoc_chain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        wr_en,
    input  logic [csoc_pkg::IDX_W-1:0]  wr_idx,
    input  logic                        launch,
    input  csoc_pkg::span_t             query,
    output csoc_pkg::probe_t            result
);
    import csoc_pkg::*;

    probe_t probe [0:MAX_SPANS];

    assign probe[0].tok = launch;
    assign probe[0].hit = 1'b0;

    for (genvar i = 0; i < MAX_SPANS; i++)
    begin : g_cell
        csoc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear),
            .wr_en     (wr_en && (wr_idx == IDX_W'(i))),
            .query     (query),
            .probe_in  (probe[i]),
            .probe_out (probe[i+1])
        );
    end

    assign result = probe[MAX_SPANS];

endmodule

/* hdl/chunk_span_overlap_checker.sv */
// channel | dir | handshake              | payload
// s_*     | in  | s_tvalid / s_tready    | tdata: chunk_offset, packed_len, raw_len; tuser: start_set
// m_*     | out | m_tvalid / m_tready    | tdata: status, stored_len
// cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat at a time: a chunk's result waits for the probe walking the row of
// span cells, one cell per cycle. Items failing the size/bounds/region checks,
// or arriving after a failure, skip the walk and go straight to the finish.
// The result register frees the input side: the next beat is taken while a
// result waits. m_tready low stalls only the finish.
// Reset (rst_n, async) empties the span table, clears the failure and regs.
module chunk_span_overlap_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csoc_pkg::IN_DATA_W-1:0]       s_tdata,   // chunk_offset, packed_len, raw_len
    input  logic                                 s_tuser,   // start_set
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csoc_pkg::OUT_DATA_W-1:0]      m_tdata,   // status, stored_len, zero pad
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csoc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csoc_pkg::ADDR_W-1:0]          cfg_data
);
    import csoc_pkg::*;

    fsm_t               state_reg, state_next;
    logic [ADDR_W-1:0]  archive_len_reg, header_end_reg, names_start_reg, names_end_reg;
    logic               start_reg;
    logic [ADDR_W-1:0]  off_reg;
    logic [LEN_W-1:0]   stored_reg;
    logic [LEN_W-1:0]   raw_reg;
    logic [ADDR_W-1:0]  qend_reg, qend_next;
    status_t            status_reg, status_next;
    logic               failed_reg, failed_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               launch_reg, launch_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic               out_load;
    logic               clear;
    logic               wr_en;
    logic [ADDR_W:0]    end_sum;
    logic               in_fire;
    span_t              query;
    probe_t             result;

    assign s_tready  = (state_reg == FSM_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign query.start = off_reg;
    assign query.stop  = qend_reg;

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        failed_next  = failed_reg;
        count_next   = count_reg;
        qend_next    = qend_reg;
        launch_next  = 1'b0;
        clear        = 1'b0;
        wr_en        = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        end_sum      = {1'b0, off_reg} + {{(ADDR_W + 1 - LEN_W){1'b0}}, stored_reg};

        case (state_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = FSM_CHECK;
                end
            end
            FSM_CHECK:
            begin
                qend_next  = end_sum[ADDR_W-1:0];
                state_next = FSM_FINISH;
                if (start_reg)
                begin
                    clear       = 1'b1;
                    count_next  = '0;
                    failed_next = 1'b0;
                end
                if (failed_reg && !start_reg)
                begin
                    status_next = ST_FAILED;
                end
                else if (stored_reg == '0 || raw_reg == '0)
                begin
                    status_next = ST_BAD_SIZE;
                    failed_next = 1'b1;
                end
                else if (end_sum[ADDR_W] || end_sum[ADDR_W-1:0] > archive_len_reg)
                begin
                    status_next = ST_OUTSIDE;
                    failed_next = 1'b1;
                end
                else if (off_reg < header_end_reg)
                begin
                    status_next = ST_HEADER;
                    failed_next = 1'b1;
                end
                else if (names_end_reg > names_start_reg && off_reg < names_end_reg
                         && names_start_reg < end_sum[ADDR_W-1:0])
                begin
                    status_next = ST_NAMES;
                    failed_next = 1'b1;
                end
                else
                begin
                    launch_next = 1'b1;
                    state_next  = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (result.tok)
                begin
                    state_next = FSM_FINISH;
                    if (result.hit)
                    begin
                        status_next = ST_OVERLAP;
                        failed_next = 1'b1;
                    end
                    else if (count_reg == CNT_W'(MAX_SPANS))
                    begin
                        status_next = ST_FULL;
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        wr_en       = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            FSM_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_IDLE;
            failed_reg      <= 1'b0;
            count_reg       <= '0;
            launch_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            archive_len_reg <= '0;
            header_end_reg  <= '0;
            names_start_reg <= '0;
            names_end_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            failed_reg  <= failed_next;
            count_reg   <= count_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ARCHIVE_LEN: archive_len_reg <= cfg_data;
                    REG_HEADER_END:  header_end_reg  <= cfg_data;
                    REG_NAMES_START: names_start_reg <= cfg_data;
                    REG_NAMES_END:   names_end_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qend_reg   <= qend_next;
        status_reg <= status_next;
        if (in_fire)
        begin
            start_reg  <= s_tuser;
            off_reg    <= s_tdata[ADDR_W-1:0];
            raw_reg    <= s_tdata[ADDR_W+2*LEN_W-1:ADDR_W+LEN_W];
            stored_reg <= (s_tdata[ADDR_W+LEN_W-1:ADDR_W] != '0)
                          ? s_tdata[ADDR_W+LEN_W-1:ADDR_W]
                          : s_tdata[ADDR_W+2*LEN_W-1:ADDR_W+LEN_W];
        end
        if (out_load)
        begin
            m_data_reg <= {{(OUT_DATA_W - LEN_W - 3){1'b0}}, stored_reg, status_reg};
        end
    end

    csoc_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (clear),
        .wr_en  (wr_en),
        .wr_idx (count_reg[IDX_W-1:0]),
        .launch (launch_reg),
        .query  (query),
        .result (result)
    );

endmodule

/* tb/sv/tb_chunk_span_overlap_checker.sv */
module tb_chunk_span_overlap_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import csoc_pkg::*;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] STD_ARCHIVE = 64'h1_0000;
    localparam logic [63:0] STD_HEADER = 64'h100;
    localparam logic [63:0] STD_NAMES_LO = 64'hF000;
    localparam logic [63:0] STD_NAMES_HI = 64'hF800;

    typedef struct {
        status_t     status;
        logic [31:0] stored;
    } chunk_verdict_t;

    class span_oracle;
        logic [63:0] archive_len;
        logic [63:0] hdr_end;
        logic [63:0] nm_start;
        logic [63:0] nm_end;
        logic [63:0] span_base [MAX_SPANS];
        logic [31:0] span_size [MAX_SPANS];
        int unsigned span_cnt;
        bit          failed;
        chunk_verdict_t pending_verdicts [$];
        int          errors;
        int          checked;

        function new();
            archive_len = '0;
            hdr_end = '0;
            nm_start = '0;
            nm_end = '0;
            span_cnt = 0;
            failed = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] val);
            case (idx)
                REG_ARCHIVE_LEN: archive_len = val;
                REG_HEADER_END:  hdr_end = val;
                REG_NAMES_START: nm_start = val;
                REG_NAMES_END:   nm_end = val;
                default: ;
            endcase
        endfunction

        // runs the checks in status order; records the span when it passes
        function status_t admit_chunk(logic [63:0] off, logic [31:0] stored, logic [31:0] raw);
            logic [64:0] stop;
            logic [64:0] prev_stop;
            if (stored == 0 || raw == 0)
                return ST_BAD_SIZE;
            stop = {1'b0, off} + {33'b0, stored};
            if (stop[64] || stop[63:0] > archive_len)
                return ST_OUTSIDE;
            if (off < hdr_end)
                return ST_HEADER;
            if (nm_end > nm_start && off < nm_end && {1'b0, nm_start} < stop)
                return ST_NAMES;
            for (int i = 0; i < span_cnt; i++)
            begin
                if (span_base[i] == off && span_size[i] == stored)
                    continue;
                prev_stop = {1'b0, span_base[i]} + {33'b0, span_size[i]};
                if ({1'b0, span_base[i]} < stop && {1'b0, off} < prev_stop)
                    return ST_OVERLAP;
            end
            if (span_cnt >= MAX_SPANS)
                return ST_FULL;
            span_base[span_cnt] = off;
            span_size[span_cnt] = stored;
            span_cnt++;
            return ST_OK;
        endfunction

        function void note_chunk(bit start, logic [63:0] off, logic [31:0] pk, logic [31:0] raw);
            chunk_verdict_t v;
            v.stored = (pk != 0) ? pk : raw;
            if (start)
            begin
                span_cnt = 0;
                failed = 1'b0;
            end
            if (failed)
                v.status = ST_FAILED;
            else
            begin
                v.status = admit_chunk(off, v.stored, raw);
                if (v.status != ST_OK)
                    failed = 1'b1;
            end
            pending_verdicts = {pending_verdicts, v};
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] beat);
            chunk_verdict_t want;
            logic [2:0]  got_status;
            logic [31:0] got_stored;
            got_status = beat[2:0];
            got_stored = beat[34:3];
            checked++;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result beat with no chunk pending: status %0d len %08h",
                             got_status, got_stored);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got_status !== want.status || got_stored !== want.stored)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d: exp status %0d len %08h, got status %0d len %08h",
                             checked, want.status, want.stored, got_status, got_stored);
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;   // chunk_offset, packed_len, raw_len
    logic                   s_tuser;   // start_set
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;   // status, stored_len, zero pad
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [ADDR_W-1:0]      cfg_data;

    span_oracle oracle = new();
    bit quiet_tail = 1'b0;

    chunk_span_overlap_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stall bursts plus one long hold-off
    initial
    begin : result_sink
        int stall_left;
        bit held;
        stall_left = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                oracle.check_result(m_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!held && oracle.checked >= 40)
            begin
                held = 1'b1;
                stall_left = 1199;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        oracle.set_reg(idx, val);
    endtask

    task automatic configure(logic [63:0] arch, logic [63:0] hdr, logic [63:0] nlo,
                             logic [63:0] nhi);
        write_reg(REG_ARCHIVE_LEN, arch);
        write_reg(REG_HEADER_END, hdr);
        write_reg(REG_NAMES_START, nlo);
        write_reg(REG_NAMES_END, nhi);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (oracle.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic offer_chunk(bit start, logic [63:0] off, logic [31:0] pk, logic [31:0] raw);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {raw, pk, off};
        do @(posedge clk); while (!s_tready);
        oracle.note_chunk(start, off, pk, raw);
    endtask

    function automatic void split_len(logic [31:0] len, output logic [31:0] pk,
                                      output logic [31:0] raw);
        if ($urandom_range(0, 1))
        begin
            pk  = len;
            raw = $urandom | 32'h1;
        end
        else
        begin
            pk  = 32'h0;
            raw = len;
        end
    endfunction

    // runs of chunks opened by start_set: mostly fresh spans laid end to end,
    // with duplicates, shifted overlaps, stray offsets and zero sizes mixed in
    task automatic run_sequences(int n_items, logic [63:0] rlo, logic [63:0] noise_hi,
                                 int unsigned lenmax);
        logic [63:0] cursor;
        logic [63:0] off;
        logic [63:0] last_off;
        logic [31:0] len;
        logic [31:0] last_len;
        logic [31:0] pk;
        logic [31:0] raw;
        int run_len;
        int pick;
        int k;
        bit start;
        k = 0;
        while (k < n_items)
        begin
            run_len = $urandom_range(3, 20);
            cursor = rlo + $urandom_range(0, 255);
            last_off = cursor;
            last_len = 0;
            for (int j = 0; j < run_len && k < n_items; j++)
            begin
                pick = $urandom_range(0, 99);
                start = (j == 0) || ($urandom_range(0, 49) == 0);
                if (pick < 70 || last_len == 0)
                begin
                    len = $urandom_range(1, lenmax);
                    off = cursor + $urandom_range(0, 3);
                    cursor = off + len;
                    last_off = off;
                    last_len = len;
                end
                else if (pick < 80)
                begin
                    off = last_off;
                    len = last_len;
                end
                else if (pick < 87)
                begin
                    off = last_off + $urandom_range(1, 3);
                    len = last_len;
                end
                else if (pick < 94)
                begin
                    off = {$urandom, $urandom} % noise_hi;
                    len = $urandom_range(1, lenmax);
                end
                else
                begin
                    off = cursor;
                    len = 32'h0;
                end
                split_len(len, pk, raw);
                if (pick >= 94 && $urandom_range(0, 1))
                begin
                    pk  = $urandom;
                    raw = 32'h0;
                end
                offer_chunk(start, off, pk, raw);
                k++;
            end
        end
    endtask

    // fills every table entry; the chunk after that hits the capacity limit
    task automatic fill_table(logic [63:0] base);
        logic [63:0] cursor;
        logic [63:0] off;
        logic [63:0] last_off;
        logic [31:0] len;
        logic [31:0] last_len;
        logic [31:0] pk;
        logic [31:0] raw;
        cursor = base;
        last_off = base;
        last_len = 0;
        for (int j = 0; j < MAX_SPANS + 4; j++)
        begin
            if (j > 0 && $urandom_range(0, 9) == 0)
            begin
                off = last_off;
                len = last_len;
            end
            else
            begin
                len = $urandom;
                if (len == 0)
                    len = 1;
                off = cursor;
                cursor = off + len;
            end
            split_len(len, pk, raw);
            offer_chunk(j == 0, off, pk, raw);
            last_off = off;
            last_len = len;
        end
        offer_chunk(1'b1, base, 32'h1, 32'h1);
    endtask

    initial
    begin : stimulus
        logic [63:0] base;
        logic [63:0] arch;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: nothing fits in a zero-length archive
        offer_chunk(1'b0, 64'h0, 32'h1, 32'h1);
        drain();
        configure(STD_ARCHIVE, STD_HEADER, STD_NAMES_LO, STD_NAMES_HI);

        offer_chunk(1'b1, 64'h100, 32'h0, 32'h10);
        offer_chunk(1'b0, 64'h200, 32'h20, 32'h40);
        offer_chunk(1'b0, 64'h200, 32'h20, 32'h7);
        offer_chunk(1'b0, 64'h300, 32'h10, 32'h1);
        offer_chunk(1'b0, 64'h310, 32'h10, 32'h1);
        offer_chunk(1'b0, 64'h300, 32'h20, 32'h1);
        offer_chunk(1'b0, 64'h400, 32'h1, 32'h1);
        offer_chunk(1'b0, 64'h0, 32'h0, 32'h0);
        offer_chunk(1'b1, 64'h500, 32'h0, 32'h0);
        offer_chunk(1'b1, 64'h500, 32'h5, 32'h0);
        offer_chunk(1'b1, 64'hFFF0, 32'h10, 32'h1);
        offer_chunk(1'b1, 64'hFFF1, 32'h10, 32'h1);
        offer_chunk(1'b1, 64'hFF, 32'h1, 32'h1);
        offer_chunk(1'b1, 64'hEFFF, 32'h1, 32'h1);
        offer_chunk(1'b0, 64'hF800, 32'h10, 32'h1);
        offer_chunk(1'b0, 64'hEFFF, 32'h2, 32'h1);
        offer_chunk(1'b1, 64'hF7FF, 32'h1, 32'h1);
        offer_chunk(1'b1, 64'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // full address range, empty name table
        configure(ALL_ONES, 64'h0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        offer_chunk(1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 32'h10, 32'h1);
        offer_chunk(1'b1, 64'hFFFF_FFFF_FFFF_FFEF, 32'h10, 32'h1);
        offer_chunk(1'b0, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_chunk(1'b0, 64'h8000_0000_0000_0000, 32'h1, 32'h1);
        offer_chunk(1'b0, ALL_ONES, 32'h1, 32'h1);
        offer_chunk(1'b1, 64'h10, 32'h10, 32'h0);
        drain();

        configure(STD_ARCHIVE, STD_HEADER, STD_NAMES_LO, STD_NAMES_HI);
        run_sequences(80, STD_HEADER, STD_ARCHIVE + 64'h100, 64);
        drain();

        // reversed name table forbids nothing
        configure(ALL_ONES, 64'h1000, ALL_ONES, 64'h0);
        base = {$urandom, $urandom};
        if (base > 64'hFFFF_FE00_0000_0000)
            base = base - 64'h0000_0200_0000_0000;
        if (base < 64'h1000)
            base = 64'h1000;
        fill_table(base);
        drain();

        arch = {1'b1, 31'($urandom), 32'($urandom)};
        configure(arch, 64'h0000_1000_0000_0000, 64'h4000_0000_0000_0000,
                  64'h4000_0000_0100_0000);
        run_sequences(50, 64'h2000_0000_0000_0000, arch, 32'hFFFF_FFFF);
        drain();

        configure(64'h0, ALL_ONES, 64'h0, ALL_ONES);
        run_sequences(16, 64'h0, ALL_ONES, 32'hFFFF_FFFF);
        drain();

        quiet_tail = 1'b1;
        configure(STD_ARCHIVE, STD_HEADER, STD_NAMES_LO, STD_NAMES_HI);
        run_sequences(40, STD_HEADER, STD_ARCHIVE + 64'h100, 64);
        drain();
        repeat (MAX_SPANS + 16) @(posedge clk);

        if (oracle.errors == 0 && oracle.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
